FILE: rtl/efti_pkg.sv
package efti_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COORD_WIDTH = 32;

    localparam int CNT_W   = 8;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int IDX_W   = 3;

    // |x|, |y| below 2.0 after the escape test
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = FRAC_BITS + 2;
    localparam int XY_W   = FRAC_BITS + 3;
    localparam int SUM_W  = FRAC_BITS + 3;
    localparam int DIFF_W = SQ_W + 1;
    localparam int Z_W    = ((COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH : FRAC_BITS + 3) + 2;

    localparam int LOOP_DEPTH = 4;
    localparam int TAG_W      = $clog2(LOOP_DEPTH);

    localparam logic [Z_W-1:0]   TWO_Z    = Z_W'(2) << FRAC_BITS;
    localparam logic [SUM_W-1:0] FOUR_SUM = SUM_W'(4) << FRAC_BITS;

    localparam logic [1:0] MODE_JULIA  = 2'd1;
    localparam logic [1:0] MODE_MANDEL = 2'd2;

    localparam logic [1:0]        MODE_RESET  = MODE_MANDEL;
    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(100);
    localparam logic [CH_W-1:0]   STEP_RESET  = CH_W'(2);
    localparam logic [COORD_WIDTH-1:0] JULIA_RESET =
        COORD_WIDTH'((64'd36 << FRAC_BITS) / 64'd100);

    typedef enum logic [IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_LIMIT = 3'd1,
        REG_JRE   = 3'd2,
        REG_JIM   = 3'd3,
        REG_RSTEP = 3'd4,
        REG_GSTEP = 3'd5,
        REG_BSTEP = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [CNT_W-1:0]              limit;
        logic signed [COORD_WIDTH-1:0] jre;
        logic signed [COORD_WIDTH-1:0] jim;
        logic [CH_W-1:0]               rstep;
        logic [CH_W-1:0]               gstep;
        logic [CH_W-1:0]               bstep;
    } cfg_t;

    typedef struct packed {
        logic                          valid;
        logic                          done;
        logic [TAG_W-1:0]              tag;
        logic [CNT_W-1:0]              count;
        logic signed [Z_W-1:0]         x;
        logic signed [Z_W-1:0]         y;
        logic signed [COORD_WIDTH-1:0] cr;
        logic signed [COORD_WIDTH-1:0] ci;
    } tok_t;

    typedef struct packed {
        logic                          valid;
        logic                          done;
        logic [TAG_W-1:0]              tag;
        logic [CNT_W-1:0]              count;
        logic [MAG_W-1:0]              ax;
        logic [MAG_W-1:0]              ay;
        logic                          neg;
        logic signed [COORD_WIDTH-1:0] cr;
        logic signed [COORD_WIDTH-1:0] ci;
    } mag_tok_t;

    typedef struct packed {
        logic                          valid;
        logic                          done;
        logic [TAG_W-1:0]              tag;
        logic [CNT_W-1:0]              count;
        logic [SQ_W-1:0]               sx;
        logic [SQ_W-1:0]               sy;
        logic [XY_W-1:0]               sxy;
        logic                          neg;
        logic signed [COORD_WIDTH-1:0] cr;
        logic signed [COORD_WIDTH-1:0] ci;
    } sq_tok_t;

    typedef struct packed {
        logic                          valid;
        logic                          done;
        logic [TAG_W-1:0]              tag;
        logic [CNT_W-1:0]              count;
        logic signed [DIFF_W-1:0]      diff;
        logic [XY_W-1:0]               sxy;
        logic                          neg;
        logic signed [COORD_WIDTH-1:0] cr;
        logic signed [COORD_WIDTH-1:0] ci;
    } diff_tok_t;

    // 255 - count*step, clamped at zero
    function automatic logic [CH_W-1:0] chan_value(input logic [CNT_W-1:0] count,
                                                   input logic [CH_W-1:0]  step);
        logic [CNT_W+CH_W-1:0] d;
        d = (CNT_W+CH_W)'(count) * (CNT_W+CH_W)'(step);
        return (d >= (CNT_W+CH_W)'(255)) ? '0 : CH_W'((CNT_W+CH_W)'(255) - d);
    endfunction

endpackage

FILE: rtl/efti_cfg.sv
module efti_cfg
    import efti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:  cfg_next.mode  = cfg_data[1:0];
                REG_LIMIT: cfg_next.limit = cfg_data[CNT_W-1:0];
                REG_JRE:   cfg_next.jre   = cfg_data;
                REG_JIM:   cfg_next.jim   = cfg_data;
                REG_RSTEP: cfg_next.rstep = cfg_data[CH_W-1:0];
                REG_GSTEP: cfg_next.gstep = cfg_data[CH_W-1:0];
                REG_BSTEP: cfg_next.bstep = cfg_data[CH_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= MODE_RESET;
            cfg_reg.limit <= LIMIT_RESET;
            cfg_reg.jre   <= JULIA_RESET;
            cfg_reg.jim   <= JULIA_RESET;
            cfg_reg.rstep <= STEP_RESET;
            cfg_reg.gstep <= STEP_RESET;
            cfg_reg.bstep <= STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/efti_loop.sv
module efti_loop
    import efti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] point_re,
    input  logic [COORD_WIDTH-1:0] point_im,
    output logic                   ret_valid,
    input  logic                   ret_ready,
    output logic [CNT_W-1:0]       ret_count
);

    // four-stage iteration ring: magnitude, square, escape/diff, update
    tok_t      p0_reg, p0_next;
    mag_tok_t  p1_reg, p1_next;
    sq_tok_t   p2_reg, p2_next;
    diff_tok_t p3_reg, p3_next;

    logic [TAG_W-1:0] in_seq_reg, in_seq_next;
    logic [TAG_W-1:0] out_seq_reg, out_seq_next;

    tok_t             head;
    tok_t             init;
    logic             retire;
    logic             take;
    logic [Z_W-1:0]   ax_full;
    logic [Z_W-1:0]   ay_full;
    logic             big;
    logic [PROD_W-1:0] pxx;
    logic [PROD_W-1:0] pyy;
    logic [PROD_W-1:0] pxy;
    logic [SUM_W-1:0] sum;
    logic             upd;
    logic [Z_W-1:0]   sxy_z;

    // oldest word retires from the head slot, in order
    assign ret_valid = p0_reg.valid && p0_reg.done && (p0_reg.tag == out_seq_reg);
    assign ret_count = p0_reg.count;
    assign retire    = ret_valid && ret_ready;
    assign in_ready  = !p0_reg.valid || retire;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        init       = '0;
        init.valid = 1'b1;
        init.tag   = in_seq_reg;
        if (cfg.mode == MODE_JULIA)
        begin
            init.x  = Z_W'($signed(point_re));
            init.y  = Z_W'($signed(point_im));
            init.cr = cfg.jre;
            init.ci = cfg.jim;
        end
        else if (cfg.mode == MODE_MANDEL)
        begin
            init.cr = point_re;
            init.ci = point_im;
        end
        else
        begin
            init.done = 1'b1;
        end
    end

    always_comb
    begin
        if (take)
            head = init;
        else if (retire)
            head = '0;
        else
            head = p0_reg;
    end

    assign in_seq_next  = take   ? in_seq_reg + 1'b1  : in_seq_reg;
    assign out_seq_next = retire ? out_seq_reg + 1'b1 : out_seq_reg;

    // stage A: magnitudes, iteration limit and early escape
    always_comb
    begin
        ax_full       = head.x[Z_W-1] ? (~head.x + 1'b1) : head.x;
        ay_full       = head.y[Z_W-1] ? (~head.y + 1'b1) : head.y;
        big           = (ax_full >= TWO_Z) || (ay_full >= TWO_Z);
        p1_next.valid = head.valid;
        p1_next.done  = head.done || (head.valid && ((head.count >= cfg.limit) || big));
        p1_next.tag   = head.tag;
        p1_next.count = head.count;
        p1_next.ax    = ax_full[MAG_W-1:0];
        p1_next.ay    = ay_full[MAG_W-1:0];
        p1_next.neg   = head.x[Z_W-1] ^ head.y[Z_W-1];
        p1_next.cr    = head.cr;
        p1_next.ci    = head.ci;
    end

    // stage B: squares and cross product
    always_comb
    begin
        pxx           = PROD_W'(p1_reg.ax) * PROD_W'(p1_reg.ax);
        pyy           = PROD_W'(p1_reg.ay) * PROD_W'(p1_reg.ay);
        pxy           = PROD_W'(p1_reg.ax) * PROD_W'(p1_reg.ay);
        p2_next.valid = p1_reg.valid;
        p2_next.done  = p1_reg.done;
        p2_next.tag   = p1_reg.tag;
        p2_next.count = p1_reg.count;
        p2_next.sx    = pxx[FRAC_BITS +: SQ_W];
        p2_next.sy    = pyy[FRAC_BITS +: SQ_W];
        p2_next.sxy   = pxy[FRAC_BITS-1 +: XY_W];
        p2_next.neg   = p1_reg.neg;
        p2_next.cr    = p1_reg.cr;
        p2_next.ci    = p1_reg.ci;
    end

    // stage C: |z|^2 test and real difference
    always_comb
    begin
        sum           = SUM_W'(p2_reg.sx) + SUM_W'(p2_reg.sy);
        p3_next.valid = p2_reg.valid;
        p3_next.done  = p2_reg.done || (p2_reg.valid && (sum >= FOUR_SUM));
        p3_next.tag   = p2_reg.tag;
        p3_next.count = p2_reg.count;
        p3_next.diff  = $signed({1'b0, p2_reg.sx}) - $signed({1'b0, p2_reg.sy});
        p3_next.sxy   = p2_reg.sxy;
        p3_next.neg   = p2_reg.neg;
        p3_next.cr    = p2_reg.cr;
        p3_next.ci    = p2_reg.ci;
    end

    // stage D: add c, bump count
    always_comb
    begin
        upd           = p3_reg.valid && !p3_reg.done;
        sxy_z         = Z_W'(p3_reg.sxy);
        p0_next.valid = p3_reg.valid;
        p0_next.done  = p3_reg.done;
        p0_next.tag   = p3_reg.tag;
        p0_next.count = p3_reg.count + CNT_W'(upd);
        p0_next.x     = Z_W'($signed(p3_reg.diff)) + Z_W'($signed(p3_reg.cr));
        p0_next.y     = (p3_reg.neg ? (~sxy_z + 1'b1) : sxy_z) + Z_W'($signed(p3_reg.ci));
        p0_next.cr    = p3_reg.cr;
        p0_next.ci    = p3_reg.ci;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg      <= '0;
            p1_reg      <= '0;
            p2_reg      <= '0;
            p3_reg      <= '0;
            in_seq_reg  <= '0;
            out_seq_reg <= '0;
        end
        else
        begin
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p3_next;
            in_seq_reg  <= in_seq_next;
            out_seq_reg <= out_seq_next;
        end
    end

endmodule

FILE: rtl/efti_out.sv
module efti_out
    import efti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               ret_valid,
    output logic               ret_ready,
    input  logic [CNT_W-1:0]   ret_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CNT_W-1:0]   escape_count,
    output logic [COLOR_W-1:0] pixel_color
);

    logic               valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    assign ret_ready    = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign escape_count = count_reg;
    assign pixel_color  = color_reg;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        color_next = color_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (ret_valid && ret_ready)
        begin
            valid_next = 1'b1;
            count_next = ret_count;
            color_next = {chan_value(ret_count, cfg.rstep),
                          chan_value(ret_count, cfg.gstep),
                          chan_value(ret_count, cfg.bstep)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        color_reg <= color_next;
    end

endmodule

FILE: rtl/escape_time_fractal_iterator_unit.sv
// Order: results leave in input order; a finished word keeps circulating
// in the ring while an older word is still running.
// Capacity: the 4-stage iteration ring holds up to 4 words, so new words
// are taken while older ones still iterate.
// Reset: async active low; empties the ring and output register, loads
// register defaults (Mandelbrot, limit 100, Julia c 0.36+0.36i, steps 2).
module escape_time_fractal_iterator_unit
    import efti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] point_re,
    input  logic [COORD_WIDTH-1:0] point_im,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CNT_W-1:0]       escape_count,
    output logic [COLOR_W-1:0]     pixel_color,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    cfg_t             cfg;
    logic             ret_valid;
    logic             ret_ready;
    logic [CNT_W-1:0] ret_count;

    efti_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    efti_loop u_loop (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .point_re  (point_re),
        .point_im  (point_im),
        .ret_valid (ret_valid),
        .ret_ready (ret_ready),
        .ret_count (ret_count)
    );

    efti_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .ret_valid    (ret_valid),
        .ret_ready    (ret_ready),
        .ret_count    (ret_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .pixel_color  (pixel_color)
    );

endmodule

FILE: rtl/efti_checker.sv
module efti_checker
    import efti_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [CNT_W-1:0]   escape_count,
    input logic [COLOR_W-1:0] pixel_color
);

    localparam int OCC_W = $clog2(LOOP_DEPTH + 2);

    logic [OCC_W-1:0] occ_reg, occ_next;

    // words accepted but not yet delivered
    assign occ_next = occ_reg + OCC_W'(in_valid && in_ready) - OCC_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(escape_count) && $stable(pixel_color))
        else $error("output word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("output word without an accepted input");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(LOOP_DEPTH + 1))
        else $error("more words in flight than slots");

    a_zero_white: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && escape_count == '0 |-> pixel_color == {COLOR_W{1'b1}})
        else $error("zero count must give full color");

endmodule

bind escape_time_fractal_iterator_unit efti_checker u_efti_checker (.*);

FILE: verif/escape_time_fractal_checker.sv
`timescale 1ns / 1ps

module escape_time_fractal_checker
    import efti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] point_re,
    input  logic [COORD_WIDTH-1:0] point_im,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [CNT_W-1:0]       escape_count,
    input  logic [COLOR_W-1:0]     pixel_color,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    output int                     fail_count,
    output int                     pending_words
);

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] color;
    } pixel_t;

    cfg_t   regs;
    pixel_t expected_pixels[$];
    int     mismatches;

    function automatic logic [CH_W-1:0] fade(input int unsigned n,
                                             input logic [CH_W-1:0] step);
        int unsigned d;
        d = n * step;
        return (d >= 255) ? '0 : CH_W'(255 - d);
    endfunction

    function automatic pixel_t predict_pixel(input cfg_t c,
                                             input logic [COORD_WIDTH-1:0] pre,
                                             input logic [COORD_WIDTH-1:0] pim);
        longint      x, y, cr, ci, t;
        logic [63:0] ax, ay, sx, sy, sxy, two, four;
        int unsigned n;
        bit          run;
        pixel_t      p;
        two  = 64'(2) << FRAC_BITS;
        four = 64'(4) << FRAC_BITS;
        n    = 0;
        run  = 1'b1;
        x = 0;
        y = 0;
        cr = 0;
        ci = 0;
        if (c.mode == MODE_JULIA) begin
            x  = longint'($signed(pre));
            y  = longint'($signed(pim));
            cr = longint'(c.jre);
            ci = longint'(c.jim);
        end else if (c.mode == MODE_MANDEL) begin
            cr = longint'($signed(pre));
            ci = longint'($signed(pim));
        end else begin
            run = 1'b0;
        end
        while (run && n < c.limit) begin
            ax = (x < 0) ? 64'(-x) : 64'(x);
            ay = (y < 0) ? 64'(-y) : 64'(y);
            if (ax >= two || ay >= two)
                break;
            sx = (ax * ax) >> FRAC_BITS;
            sy = (ay * ay) >> FRAC_BITS;
            if (sx + sy >= four)
                break;
            sxy = ((ax << 1) * ay) >> FRAC_BITS;
            t = longint'(sx) - longint'(sy) + cr;
            y = (((x < 0) != (y < 0)) ? -longint'(sxy) : longint'(sxy)) + ci;
            x = t;
            n++;
        end
        p.count = CNT_W'(n);
        p.color = {fade(n, c.rstep), fade(n, c.gstep), fade(n, c.bstep)};
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            regs.mode  = MODE_RESET;
            regs.limit = LIMIT_RESET;
            regs.jre   = JULIA_RESET;
            regs.jim   = JULIA_RESET;
            regs.rstep = STEP_RESET;
            regs.gstep = STEP_RESET;
            regs.bstep = STEP_RESET;
            expected_pixels.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_words <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:  regs.mode  = cfg_data[1:0];
                    REG_LIMIT: regs.limit = cfg_data[CNT_W-1:0];
                    REG_JRE:   regs.jre   = cfg_data;
                    REG_JIM:   regs.jim   = cfg_data;
                    REG_RSTEP: regs.rstep = cfg_data[CH_W-1:0];
                    REG_GSTEP: regs.gstep = cfg_data[CH_W-1:0];
                    REG_BSTEP: regs.bstep = cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(predict_pixel(regs, point_re, point_im));
            if (out_valid && out_ready)
            begin
                got.count = escape_count;
                got.color = pixel_color;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word count %0d color %06h",
                                 $realtime, got.count, got.color);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.count != want.count || got.color != want.color)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch count exp %0d got %0d, color exp %06h got %06h",
                                     $realtime, want.count, got.count, want.color, got.color);
                    end
                end
            end
            fail_count    <= mismatches;
            pending_words <= expected_pixels.size();
        end
    end

endmodule

FILE: verif/tb_escape_time_fractal_iterator_unit.sv
`timescale 1ns / 1ps

module tb_escape_time_fractal_iterator_unit;
    import efti_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 1100;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Q4.28 values
    localparam logic [COORD_WIDTH-1:0] Q_ONE     = 32'h1000_0000;
    localparam logic [COORD_WIDTH-1:0] Q_TWO     = 32'h2000_0000;
    localparam logic [COORD_WIDTH-1:0] Q_NEG_TWO = 32'hE000_0000;
    localparam logic [COORD_WIDTH-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [COORD_WIDTH-1:0] Q_MIN     = 32'h8000_0000;
    localparam int unsigned SPAN_PLANE = 603979776;   // 2.25
    localparam int unsigned SPAN_NEAR  = 268435456;   // 1.0
    localparam int unsigned SPAN_FULL  = 0;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [COORD_WIDTH-1:0] point_re;
    logic [COORD_WIDTH-1:0] point_im;
    logic                   out_valid;
    logic                   out_ready;
    logic [CNT_W-1:0]       escape_count;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;

    int fail_count;
    int pending_words;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int quiet_cycles = 0;

    escape_time_fractal_iterator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_re     (point_re),
        .point_im     (point_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .pixel_color  (pixel_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    escape_time_fractal_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .point_re      (point_re),
        .point_im      (point_im),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .escape_count  (escape_count),
        .pixel_color   (pixel_color),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_idle_pct != 0 && $urandom_range(1, 100) <= out_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= rst_n;
        end
    end

    function automatic cfg_t make_cfg(input logic [1:0] m, input logic [CNT_W-1:0] lim,
                                      input logic [COORD_WIDTH-1:0] re,
                                      input logic [COORD_WIDTH-1:0] im,
                                      input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                      input logic [CH_W-1:0] b);
        cfg_t c;
        c.mode  = m;
        c.limit = lim;
        c.jre   = re;
        c.jim   = im;
        c.rstep = r;
        c.gstep = g;
        c.bstep = b;
        return c;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_coord(input int unsigned span);
        if (span == SPAN_FULL)
            return $urandom();
        return COORD_WIDTH'($urandom_range(0, 2 * span)) - COORD_WIDTH'(span);
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        int   r;
        r = $urandom_range(0, 19);
        c.mode = (r == 0) ? MODE_OFF : (r == 1) ? MODE_SPARE :
                 (r < 11) ? MODE_JULIA : MODE_MANDEL;
        r = $urandom_range(0, 9);
        c.limit = (r == 0) ? CNT_W'(255) : (r == 1) ? CNT_W'(0) : (r == 2) ? CNT_W'(1) :
                  CNT_W'($urandom_range(2, 64));
        r = $urandom_range(0, 4);
        c.jre = pick_coord(r == 0 ? SPAN_FULL : SPAN_NEAR);
        c.jim = pick_coord(r == 0 ? SPAN_FULL : SPAN_NEAR);
        c.rstep = CH_W'($urandom_range(0, 255));
        c.gstep = CH_W'($urandom_range(0, 255));
        c.bstep = CH_W'($urandom_range(0, 16));
        return c;
    endfunction

    task automatic send_point(input logic [COORD_WIDTH-1:0] re,
                              input logic [COORD_WIDTH-1:0] im);
        if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_re <= re;
        point_im <= im;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_point();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            send_point(pick_coord(SPAN_FULL), pick_coord(SPAN_FULL));
        else if (r < 5)
            send_point(pick_coord(SPAN_NEAR / 8), pick_coord(SPAN_NEAR / 8));
        else
            send_point(pick_coord(SPAN_PLANE), pick_coord(SPAN_PLANE));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    task automatic configure(input cfg_t c);
        logic [COORD_WIDTH-1:0] val;
        for (int i = REG_MODE; i <= REG_BSTEP; i++)
        begin
            case (reg_idx_t'(i))
                REG_MODE:  val = COORD_WIDTH'(c.mode);
                REG_LIMIT: val = COORD_WIDTH'(c.limit);
                REG_JRE:   val = c.jre;
                REG_JIM:   val = c.jim;
                REG_RSTEP: val = COORD_WIDTH'(c.rstep);
                REG_GSTEP: val = COORD_WIDTH'(c.gstep);
                default:   val = COORD_WIDTH'(c.bstep);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        point_re  = '0;
        point_im  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: Mandelbrot, limit 100
        send_point('0, '0);
        send_point(Q_NEG_TWO, '0);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(Q_ONE, '0);
        send_point(32'hF400_0000, 32'h0199_9999);

        drain();
        configure(make_cfg(MODE_JULIA, 8'd255, Q_MIN, Q_MAX, 8'd0, 8'd255, 8'd1));
        send_point(Q_TWO, '0);
        send_point('0, Q_NEG_TWO);
        send_point('0, '0);
        send_point(Q_ONE, Q_ONE);

        drain();
        configure(make_cfg(MODE_JULIA, 8'd255, JULIA_RESET, JULIA_RESET,
                           8'd255, 8'd0, 8'd2));
        send_point('0, '0);
        send_point(32'h0400_0000, 32'h0400_0000);
        send_point(32'h1FFF_FFFF, '0);

        drain();
        configure(make_cfg(MODE_OFF, 8'd100, '0, '0, 8'd3, 8'd3, 8'd3));
        send_point('0, '0);
        send_point(Q_MAX, Q_MAX);

        drain();
        configure(make_cfg(MODE_SPARE, 8'd100, '0, '0, 8'd3, 8'd3, 8'd3));
        send_point('0, '0);
        send_point(Q_MIN, Q_MIN);

        drain();
        configure(make_cfg(MODE_MANDEL, 8'd0, '0, '0, 8'd1, 8'd1, 8'd1));
        send_point('0, '0);
        send_point(Q_ONE, Q_NEG_TWO);

        drain();
        configure(make_cfg(MODE_MANDEL, 8'd1, '0, '0, 8'd255, 8'd254, 8'd128));
        send_point('0, '0);
        send_point(Q_MAX, Q_MAX);

        for (int p = 0; p < 9; p++)
        begin
            drain();
            configure(random_cfg());
            case ($urandom_range(0, 2))
                0:       in_idle_pct = 0;
                1:       in_idle_pct = 10;
                default: in_idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       out_idle_pct = 0;
                1:       out_idle_pct = 5;
                default: out_idle_pct = 20;
            endcase
            repeat (95) send_random_point();
        end

        drain();
        configure(make_cfg(MODE_MANDEL, CNT_W'($urandom_range(1, 64)), JULIA_RESET,
                           JULIA_RESET, STEP_RESET, STEP_RESET, STEP_RESET));
        in_idle_pct  = 0;
        out_idle_pct = 0;
        repeat (45) send_random_point();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
